/* sv/mtbso_pkg.sv */
// Shared types and constants for the move-to-back service order block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtbso_pkg;

  localparam int MASK_W  = 8;
  localparam int FIELD_W = 3;
  // Wide enough to hold a handler count of up to sixteen.
  localparam int SPLIT_W = 5;

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [SPLIT_W-1:0] split;
  } round_t;

endpackage

`default_nettype wire

/* sv/mtbso_front.sv */
// Front end: accepts rounds, counts the handlers that sent and queues the result.
// Depends on mtbso_pkg.
`default_nettype none

module mtbso_front #(
  parameter int HANDLERS = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [mtbso_pkg::MASK_W-1:0] sent_mask,
  output logic                        q_valid,
  output mtbso_pkg::round_t           q_data,
  input  wire                         q_take
);
  import mtbso_pkg::*;

  logic [SPLIT_W-1:0] sent_cnt;
  round_t             entry [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;

  always_comb begin
    sent_cnt = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if ((j < HANDLERS) && sent_mask[j]) begin
        sent_cnt = sent_cnt + SPLIT_W'(1);
      end
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr].mask  <= sent_mask;
      entry[wr_ptr].split <= SPLIT_W'(HANDLERS) - sent_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, q_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/mtbso_back.sv */
// Back end: scans the current order, builds the new order in the spare bank
// and emits it through the output register. Depends on mtbso_pkg.
`default_nettype none

module mtbso_back #(
  parameter int HANDLERS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          q_valid,
  input  mtbso_pkg::round_t            q_data,
  output logic                         q_take,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [mtbso_pkg::FIELD_W-1:0] position,
  output logic [mtbso_pkg::FIELD_W-1:0] handler_id,
  output logic                         last_of_order
);
  import mtbso_pkg::*;

  localparam int IW = $clog2(HANDLERS);
  localparam int CW = $clog2(HANDLERS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(HANDLERS - 1);
  localparam logic [CW-1:0] LAST_POS = CW'(HANDLERS - 1);
  localparam logic [CW-1:0] ALL_POS  = CW'(HANDLERS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic              bank;
  logic              fresh;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     pos_next;
  logic [CW-1:0]     sptr;
  logic [MASK_W-1:0] mask;

  logic [IW-1:0] mem0 [HANDLERS];
  logic [IW-1:0] mem1 [HANDLERS];

  logic [IW-1:0] addr0;
  logic [IW-1:0] addr1;
  logic [IW-1:0] cur;
  logic [IW-1:0] drain_id;
  logic [IW-1:0] emit_id;
  logic [IW-1:0] wr_addr;
  logic          head_sent;
  logic          can_load;
  logic          scan_step;
  logic          drain_step;
  logic          emit;
  logic          finish;

  always_comb begin
    addr0     = bank ? pos[IW-1:0] : idx;
    addr1     = bank ? idx : pos[IW-1:0];
    cur       = fresh ? idx : (bank ? mem1[addr1] : mem0[addr0]);
    drain_id  = bank ? mem0[addr0] : mem1[addr1];
    head_sent = (32'(cur) < 32'(MASK_W)) && mask[FIELD_W'(cur)];
    can_load  = !out_valid || !out_stall;
    scan_step  = (state == ST_SCAN) && (head_sent || can_load);
    drain_step = (state == ST_DRAIN) && can_load;
    emit       = ((state == ST_SCAN) && !head_sent && can_load) || drain_step;
    emit_id    = (state == ST_DRAIN) ? drain_id : cur;
    pos_next   = emit ? pos + CW'(1) : pos;
    wr_addr    = head_sent ? sptr[IW-1:0] : pos[IW-1:0];
    finish     = (scan_step && (idx == LAST_IDX) && (pos_next == ALL_POS)) ||
                 (drain_step && (pos == LAST_POS));
    q_take     = q_valid && (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (scan_step) begin
      if (bank) begin
        mem0[wr_addr] <= cur;
      end else begin
        mem1[wr_addr] <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      position      <= FIELD_W'(pos);
      handler_id    <= FIELD_W'(emit_id);
      last_of_order <= (pos == LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bank      <= 1'b0;
      fresh     <= 1'b1;
      idx       <= '0;
      pos       <= '0;
      sptr      <= '0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_take) begin
            state <= ST_SCAN;
            idx   <= '0;
            pos   <= '0;
            sptr  <= CW'(q_data.split);
            mask  <= q_data.mask;
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            idx <= idx + IW'(1);
            pos <= pos_next;
            if (head_sent) begin
              sptr <= sptr + CW'(1);
            end
            if (idx == LAST_IDX) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (drain_step) begin
            pos <= pos_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        state <= ST_IDLE;
        bank  <= !bank;
        fresh <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/move_to_back_service_order.sv */
// Move-to-back service order: top level joining the front end and the back end.
// Depends on mtbso_pkg, mtbso_front and mtbso_back.
//
// Each input transaction carries sent_mask, one bit per handler that sent a
// message in a service round. The block moves those handlers to the back of
// its service order, keeping relative order on both sides, and then emits the
// whole new order as HANDLERS output transactions: position, handler_id and
// last_of_order, which is high on the final position.
// The front end counts the handlers that sent and holds up to two rounds in a
// queue, so new rounds are taken while the back end is still emitting.
// The back end scans the current order once, one handler a cycle unless a
// stalled output holds it up, emitting handlers that did not send directly
// and parking the others in the spare bank; it then emits the parked handlers.
// The first result enters the output register when the first quiet handler is
// scanned, after the back end has taken the round from the queue while idle.
// After reset the order is ascending and the queue is empty. When out_stall
// is high on a valid transaction the output register holds it and the back
// end emits nothing more; the queue fills and in_stall rises once two rounds
// are waiting.
`default_nettype none

module move_to_back_service_order #(
  parameter int HANDLERS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [mtbso_pkg::MASK_W-1:0]  sent_mask,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [mtbso_pkg::FIELD_W-1:0] position,
  output logic [mtbso_pkg::FIELD_W-1:0] handler_id,
  output logic                         last_of_order
);
  import mtbso_pkg::*;

  round_t q_data;
  logic   q_valid;
  logic   q_take;

  mtbso_front #(
    .HANDLERS (HANDLERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sent_mask (sent_mask),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_take    (q_take)
  );

  mtbso_back #(
    .HANDLERS (HANDLERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_take        (q_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .position      (position),
    .handler_id    (handler_id),
    .last_of_order (last_of_order)
  );

endmodule

`default_nettype wire

/* sv/mtbso_checker.sv */
// Port-level checks for the move-to-back service order block, bound to the top.
// Depends on mtbso_pkg and move_to_back_service_order.
`default_nettype none

module mtbso_checker #(
  parameter int HANDLERS = 8
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_stall,
  input wire [mtbso_pkg::MASK_W-1:0]  sent_mask,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [mtbso_pkg::FIELD_W-1:0] position,
  input wire [mtbso_pkg::FIELD_W-1:0] handler_id,
  input wire                          last_of_order
);
  import mtbso_pkg::*;

  localparam logic [FIELD_W-1:0] LAST_POS = FIELD_W'(HANDLERS - 1);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sent_mask))
    else $error("Stalled input transaction changed.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) &&
      $stable(handler_id) && $stable(last_of_order))
    else $error("Stalled output transaction changed.");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_order |-> position == LAST_POS)
    else $error("Last flag on the wrong position.");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_order |=>
      !out_valid || position == $past(position) + FIELD_W'(1))
    else $error("Positions not emitted in sequence.");

endmodule

bind move_to_back_service_order mtbso_checker #(.HANDLERS(HANDLERS)) u_mtbso_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for move_to_back_service_order: directed and random rounds.
// It predicts each reordered service order and checks every output transaction in turn.
// Depends on mtbso_pkg and move_to_back_service_order.
`default_nettype none

module tb_top;

  localparam int HANDLERS    = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ROUNDS = 290;
  localparam int CALM_ROUNDS = 50;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [mtbso_pkg::FIELD_W-1:0] place;
    logic [mtbso_pkg::FIELD_W-1:0] who;
    logic                          tail;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mtbso_pkg::MASK_W-1:0] sent_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mtbso_pkg::FIELD_W-1:0] position;
  logic [mtbso_pkg::FIELD_W-1:0] handler_id;
  logic last_of_order;

  logic [mtbso_pkg::FIELD_W-1:0] order_now [HANDLERS];
  logic [mtbso_pkg::MASK_W-1:0] round_queue [$];
  slot_t awaited_slots [$];

  int total_rounds = 0;
  int rounds_taken = 0;
  int slots_seen = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  move_to_back_service_order #(.HANDLERS(HANDLERS)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sent_mask(sent_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .position(position),
    .handler_id(handler_id),
    .last_of_order(last_of_order)
  );

  always #5 clk = ~clk;

  function automatic bit idling_allowed();
    return rounds_taken < total_rounds - CALM_ROUNDS && (rounds_taken / 40) % 3 != 2;
  endfunction

  // Stable partition: handlers that stayed quiet first, senders after, and
  // the whole new order becomes the awaited output transactions.
  task automatic reorder_service(input logic [mtbso_pkg::MASK_W-1:0] mask);
    logic [mtbso_pkg::FIELD_W-1:0] next_order [HANDLERS];
    int fill;
    slot_t s;
    fill = 0;
    for (int i = 0; i < HANDLERS; i++) begin
      if (!mask[order_now[i]]) begin
        next_order[fill] = order_now[i];
        fill++;
      end
    end
    for (int i = 0; i < HANDLERS; i++) begin
      if (mask[order_now[i]]) begin
        next_order[fill] = order_now[i];
        fill++;
      end
    end
    for (int i = 0; i < HANDLERS; i++) begin
      order_now[i] = next_order[i];
      s.place = i[mtbso_pkg::FIELD_W-1:0];
      s.who = next_order[i];
      s.tail = (i == HANDLERS - 1);
      awaited_slots.push_back(s);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reorder_service(sent_mask);
        rounds_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (in_valid && idling_allowed() && $urandom_range(3) == 0) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(3);
      end else if (round_queue.size() > 0) begin
        in_valid <= 1'b1;
        sent_mask <= round_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    slot_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        slots_seen++;
        if (awaited_slots.size() == 0) begin
          report_mismatch("unexpected transaction, handler_id", handler_id, -1);
        end else begin
          want = awaited_slots.pop_front();
          if (position !== want.place) report_mismatch("position", position, want.place);
          if (handler_id !== want.who) report_mismatch("handler_id", handler_id, want.who);
          if (last_of_order !== want.tail)
            report_mismatch("last_of_order", last_of_order, want.tail);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_once && slots_seen >= 300) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idling_allowed() && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [mtbso_pkg::MASK_W-1:0] directed [] = '{
      8'h00, 8'hFF, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
      8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h7F, 8'hFE, 8'h81, 8'h3C, 8'h80, 8'h00
    };
    logic [mtbso_pkg::MASK_W-1:0] m;
    for (int i = 0; i < HANDLERS; i++) order_now[i] = i[mtbso_pkg::FIELD_W-1:0];
    foreach (directed[i]) round_queue.push_back(directed[i]);
    for (int i = 0; i < RANDOM_ROUNDS; i++) begin
      case ($urandom_range(3))
        0: m = 8'($urandom);
        1: m = 8'h01 << $urandom_range(7);
        2: m = 8'($urandom & $urandom);
        default: m = 8'($urandom | $urandom);
      endcase
      round_queue.push_back(m);
    end
    total_rounds = round_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (rounds_taken < total_rounds) @(posedge clk);
    while (awaited_slots.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
